### rtl/core/plcab_pkg.sv
// Shared types, codes and constants of the pixel table and checker alpha blend core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package plcab_pkg;

    localparam int CHECK_SHIFT_DEF = 4;
    localparam int COORD_BITS_DEF  = 12;

    localparam int PIX_W       = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int OFS_W       = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [OFS_W-1:0] ofs_t;

    localparam pix_t ALPHA_OPAQUE = pix_t'(255);
    localparam pix_t ALPHA_CLEAR  = pix_t'(0);

    // Rounding term plus the bias that keeps the blend difference positive.
    localparam logic [16:0] BLEND_OFFSET = 17'd65408;

    typedef enum logic {
        CMD_TABLE_WRITE = 1'b0,
        CMD_RENDER      = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } table_ch_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA_MODE  = 3'd0,
        CFG_X_OFFSET    = 3'd1,
        CFG_Y_OFFSET    = 3'd2,
        CFG_DARK_LEVEL  = 3'd3,
        CFG_LIGHT_LEVEL = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEL_LUT   = 2'd0,
        SEL_CHECK = 2'd1,
        SEL_RAW   = 2'd2,
        SEL_BLEND = 2'd3
    } sel_t;

    localparam logic ALPHA_MODE_RESET  = 1'b0;
    localparam ofs_t X_OFFSET_RESET    = ofs_t'(0);
    localparam ofs_t Y_OFFSET_RESET    = ofs_t'(0);
    localparam pix_t DARK_LEVEL_RESET  = pix_t'(0);
    localparam pix_t LIGHT_LEVEL_RESET = pix_t'(255);

endpackage

`default_nettype wire

### rtl/core/plcab_if.sv
// Channel interfaces of the pixel table and checker alpha blend core.
// Depends on plcab_pkg for field widths and default coordinate width.
`default_nettype none

interface plcab_pixel_if #(
    parameter int COORD_BITS = plcab_pkg::COORD_BITS_DEF
);
    import plcab_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [1:0]            table_channel;
    logic [PIX_W-1:0]      table_index;
    logic [PIX_W-1:0]      table_value;
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic [PIX_W-1:0]      src_red;
    logic [PIX_W-1:0]      src_green;
    logic [PIX_W-1:0]      src_blue;
    logic [PIX_W-1:0]      src_alpha;

    modport source (
        output valid, command, table_channel, table_index, table_value,
               dest_x, dest_y, src_red, src_green, src_blue, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, command, table_channel, table_index, table_value,
               dest_x, dest_y, src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

interface plcab_result_if;
    import plcab_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

interface plcab_cfg_if;
    import plcab_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/pixel_lut_checker_alpha_blend_core.sv
// Top level of the pixel table and checker alpha blend core: color tables and a
// four-stage pixel pipeline. Depends on plcab_pkg and the interfaces in plcab_if.
//
//   channel | direction | transfer carries
//   --------+-----------+---------------------------------------------------
//   pixel   | in        | table write or pixel with coordinates and RGBA
//   result  | out       | one RGB pixel for each rendered pixel
//   cfg     | in        | register index and write data, always ready
//
// One item enters per cycle unless a result stall has filled the pipeline; a rendered
// pixel passes the input register, color table read, products and output register.
// The color table read port sets the stage split: each table is read once per cycle while the read stage advances.
// Reset clears all valid bits and the config registers; the data registers and the tables hold no reset value.
// A stall on the result channel backs up stage by stage, and empty stages keep
// taking transfers until the pipeline is full.
`default_nettype none

module pixel_lut_checker_alpha_blend_core #(
    parameter int CHECK_SHIFT = plcab_pkg::CHECK_SHIFT_DEF,
    parameter int COORD_BITS  = plcab_pkg::COORD_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    plcab_pixel_if.sink    pixel,
    plcab_result_if.source result,
    plcab_cfg_if.sink      cfg
);
    import plcab_pkg::*;

    logic alpha_mode_reg;
    ofs_t x_offset_reg;
    ofs_t y_offset_reg;
    pix_t dark_level_reg;
    pix_t light_level_reg;

    pix_t red_mem   [TABLE_DEPTH];
    pix_t green_mem [TABLE_DEPTH];
    pix_t blue_mem  [TABLE_DEPTH];

    logic                  v1_reg;
    logic                  cmd1_reg;
    logic [1:0]            ch1_reg;
    pix_t                  idx1_reg;
    pix_t                  val1_reg;
    logic [COORD_BITS-1:0] x1_reg;
    logic [COORD_BITS-1:0] y1_reg;
    pix_t                  r1_reg;
    pix_t                  g1_reg;
    pix_t                  b1_reg;
    pix_t                  a1_reg;

    logic v2_reg;
    sel_t sel2_reg;
    pix_t tr2_reg;
    pix_t tg2_reg;
    pix_t tb2_reg;
    pix_t chk2_reg;
    pix_t r2_reg;
    pix_t g2_reg;
    pix_t b2_reg;
    pix_t a2_reg;

    logic        v3_reg;
    sel_t        sel3_reg;
    pix_t        tr3_reg;
    pix_t        tg3_reg;
    pix_t        tb3_reg;
    pix_t        chk3_reg;
    pix_t        r3_reg;
    pix_t        g3_reg;
    pix_t        b3_reg;
    logic [15:0] pr3_reg;
    logic [15:0] pg3_reg;
    logic [15:0] pb3_reg;
    logic [15:0] pchk3_reg;

    logic v4_reg;
    pix_t out_r_reg;
    pix_t out_g_reg;
    pix_t out_b_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    ofs_t sum_x;
    ofs_t sum_y;
    pix_t chk_next;
    sel_t sel_next;
    logic tbl_we;

    pix_t out_r_next;
    pix_t out_g_next;
    pix_t out_b_next;

    function automatic pix_t blend8(logic [15:0] p_tv, logic [15:0] p_chk, pix_t chk);
        logic [16:0] diff;
        diff = 17'(p_tv) + BLEND_OFFSET - 17'(p_chk);
        return chk + diff[15:8] + pix_t'(1);
    endfunction

    assign rdy4 = !v4_reg || result.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign pixel.ready = rdy1;
    assign cfg.ready   = 1'b1;

    assign result.valid     = v4_reg;
    assign result.out_red   = out_r_reg;
    assign result.out_green = out_g_reg;
    assign result.out_blue  = out_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg  <= ALPHA_MODE_RESET;
            x_offset_reg    <= X_OFFSET_RESET;
            y_offset_reg    <= Y_OFFSET_RESET;
            dark_level_reg  <= DARK_LEVEL_RESET;
            light_level_reg <= LIGHT_LEVEL_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_ALPHA_MODE:  alpha_mode_reg  <= cfg.data[0];
                CFG_X_OFFSET:    x_offset_reg    <= cfg.data;
                CFG_Y_OFFSET:    y_offset_reg    <= cfg.data;
                CFG_DARK_LEVEL:  dark_level_reg  <= cfg.data[PIX_W-1:0];
                CFG_LIGHT_LEVEL: light_level_reg <= cfg.data[PIX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= pixel.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg && (cmd1_reg == CMD_RENDER);
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pixel.valid)
        begin
            cmd1_reg <= pixel.command;
            ch1_reg  <= pixel.table_channel;
            idx1_reg <= pixel.table_index;
            val1_reg <= pixel.table_value;
            x1_reg   <= pixel.dest_x;
            y1_reg   <= pixel.dest_y;
            r1_reg   <= pixel.src_red;
            g1_reg   <= pixel.src_green;
            b1_reg   <= pixel.src_blue;
            a1_reg   <= pixel.src_alpha;
        end
    end

    assign tbl_we = v1_reg && rdy2 && (cmd1_reg == CMD_TABLE_WRITE);

    always_ff @(posedge clk)
    begin
        if (tbl_we && (ch1_reg == CH_RED))
        begin
            red_mem[idx1_reg] <= val1_reg;
        end
        if (rdy2)
        begin
            tr2_reg <= red_mem[r1_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we && (ch1_reg == CH_GREEN))
        begin
            green_mem[idx1_reg] <= val1_reg;
        end
        if (rdy2)
        begin
            tg2_reg <= green_mem[g1_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we && (ch1_reg == CH_BLUE))
        begin
            blue_mem[idx1_reg] <= val1_reg;
        end
        if (rdy2)
        begin
            tb2_reg <= blue_mem[b1_reg];
        end
    end

    always_comb
    begin
        sum_x    = ofs_t'(x1_reg) + x_offset_reg;
        sum_y    = ofs_t'(y1_reg) + y_offset_reg;
        chk_next = (sum_x[CHECK_SHIFT] ^ sum_y[CHECK_SHIFT]) ? dark_level_reg
                                                            : light_level_reg;
        if (!alpha_mode_reg)
        begin
            sel_next = SEL_LUT;
        end
        else if (a1_reg == ALPHA_CLEAR)
        begin
            sel_next = SEL_CHECK;
        end
        else if (a1_reg == ALPHA_OPAQUE)
        begin
            sel_next = SEL_RAW;
        end
        else
        begin
            sel_next = SEL_BLEND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            sel2_reg <= sel_next;
            chk2_reg <= chk_next;
            r2_reg   <= r1_reg;
            g2_reg   <= g1_reg;
            b2_reg   <= b1_reg;
            a2_reg   <= a1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sel3_reg  <= sel2_reg;
            tr3_reg   <= tr2_reg;
            tg3_reg   <= tg2_reg;
            tb3_reg   <= tb2_reg;
            chk3_reg  <= chk2_reg;
            r3_reg    <= r2_reg;
            g3_reg    <= g2_reg;
            b3_reg    <= b2_reg;
            pr3_reg   <= 16'(tr2_reg) * 16'(a2_reg);
            pg3_reg   <= 16'(tg2_reg) * 16'(a2_reg);
            pb3_reg   <= 16'(tb2_reg) * 16'(a2_reg);
            pchk3_reg <= 16'(chk2_reg) * 16'(a2_reg);
        end
    end

    always_comb
    begin
        case (sel3_reg)
            SEL_LUT:
            begin
                out_r_next = tr3_reg;
                out_g_next = tg3_reg;
                out_b_next = tb3_reg;
            end
            SEL_CHECK:
            begin
                out_r_next = chk3_reg;
                out_g_next = chk3_reg;
                out_b_next = chk3_reg;
            end
            SEL_RAW:
            begin
                out_r_next = r3_reg;
                out_g_next = g3_reg;
                out_b_next = b3_reg;
            end
            default:
            begin
                out_r_next = blend8(pr3_reg, pchk3_reg, chk3_reg);
                out_g_next = blend8(pg3_reg, pchk3_reg, chk3_reg);
                out_b_next = blend8(pb3_reg, pchk3_reg, chk3_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            out_r_reg <= out_r_next;
            out_g_reg <= out_g_next;
            out_b_reg <= out_b_next;
        end
    end

    a_blend_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && (sel2_reg == SEL_BLEND)) |-> (a2_reg != ALPHA_CLEAR && a2_reg != ALPHA_OPAQUE))
        else $error("Blend selected for a fully clear or fully opaque pixel.");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy3) |=> (v3_reg && $stable(pr3_reg) && $stable(sel3_reg)))
        else $error("Product stage lost or changed a stalled pixel.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(v3_reg))
        else $error("Result appeared without a pixel in the product stage.");

endmodule

`default_nettype wire

### bench/pixel_lut_checker_alpha_blend_core_test.sv
// Self-checking bench for pixel_lut_checker_alpha_blend_core: color table loads, table
// lookups and alpha blending over the checkerboard, all checked against a predictor.
// Depends on plcab_pkg and the channel interfaces in plcab_if from the RTL.
`default_nettype none

module pixel_lut_checker_alpha_blend_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plcab_pkg::*;

    localparam int COORD_W       = COORD_BITS_DEF;
    localparam int CHECK_BIT     = CHECK_SHIFT_DEF;
    localparam int PIPE_DEPTH    = 4;
    localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASES        = 6;
    localparam int CYCLE_LIMIT   = 500000;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct {
        cmd_t       command;
        logic [1:0] table_channel;
        pix_t       table_index;
        pix_t       table_value;
        coord_t     dest_x;
        coord_t     dest_y;
        pix_t       src_red;
        pix_t       src_green;
        pix_t       src_blue;
        pix_t       src_alpha;
    } pixel_item_t;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
    } rgb_t;

    typedef struct {
        cfg_index_t            idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    class blend_scoreboard;
        pix_t red_lut[TABLE_DEPTH];
        pix_t green_lut[TABLE_DEPTH];
        pix_t blue_lut[TABLE_DEPTH];
        logic alpha_on;
        ofs_t x_ofs;
        ofs_t y_ofs;
        pix_t dark;
        pix_t light;
        rgb_t pending[$];
        int   errors;
        int   checked;

        function new();
            alpha_on = ALPHA_MODE_RESET;
            x_ofs    = X_OFFSET_RESET;
            y_ofs    = Y_OFFSET_RESET;
            dark     = DARK_LEVEL_RESET;
            light    = LIGHT_LEVEL_RESET;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ALPHA_MODE:  alpha_on = data[0];
                CFG_X_OFFSET:    x_ofs = data;
                CFG_Y_OFFSET:    y_ofs = data;
                CFG_DARK_LEVEL:  dark = data[PIX_W-1:0];
                CFG_LIGHT_LEVEL: light = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        // Rounded blend of a table value over the checker level; the arithmetic
        // shift gives the floor of the signed quotient.
        function pix_t blend_over(pix_t lut_val, pix_t chk, pix_t alpha);
            int diff;
            diff = (int'(lut_val) - int'(chk)) * int'(alpha) + 128;
            return pix_t'(int'(chk) + (diff >>> 8));
        endfunction

        function void note_input(pixel_item_t it);
            rgb_t looked_up;
            rgb_t res;
            pix_t chk;
            int   sx;
            int   sy;
            if (it.command == CMD_TABLE_WRITE)
            begin
                case (it.table_channel)
                    CH_RED:   red_lut[it.table_index] = it.table_value;
                    CH_GREEN: green_lut[it.table_index] = it.table_value;
                    CH_BLUE:  blue_lut[it.table_index] = it.table_value;
                    default: ;
                endcase
                return;
            end
            looked_up.red   = red_lut[it.src_red];
            looked_up.green = green_lut[it.src_green];
            looked_up.blue  = blue_lut[it.src_blue];
            if (!alpha_on)
            begin
                res = looked_up;
            end
            else
            begin
                sx  = int'(it.dest_x) + int'(x_ofs);
                sy  = int'(it.dest_y) + int'(y_ofs);
                chk = (sx[CHECK_BIT] ^ sy[CHECK_BIT]) ? dark : light;
                if (it.src_alpha == ALPHA_CLEAR)
                begin
                    res = {chk, chk, chk};
                end
                else if (it.src_alpha == ALPHA_OPAQUE)
                begin
                    res = {it.src_red, it.src_green, it.src_blue};
                end
                else
                begin
                    res.red   = blend_over(looked_up.red, chk, it.src_alpha);
                    res.green = blend_over(looked_up.green, chk, it.src_alpha);
                    res.blue  = blend_over(looked_up.blue, chk, it.src_alpha);
                end
            end
            pending.push_back(res);
        endfunction

        function void check_result(rgb_t got);
            rgb_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel: expected none, actual %h", $time, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.red !== want.red)
            begin
                errors++;
                $display("%0t: out_red mismatch: expected %0d, actual %0d",
                         $time, want.red, got.red);
            end
            if (got.green !== want.green)
            begin
                errors++;
                $display("%0t: out_green mismatch: expected %0d, actual %0d",
                         $time, want.green, got.green);
            end
            if (got.blue !== want.blue)
            begin
                errors++;
                $display("%0t: out_blue mismatch: expected %0d, actual %0d",
                         $time, want.blue, got.blue);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    plcab_pixel_if #(.COORD_BITS(COORD_W)) pix_if();
    plcab_result_if res_if();
    plcab_cfg_if cfg_if();

    pixel_lut_checker_alpha_blend_core #(
        .CHECK_SHIFT(CHECK_BIT),
        .COORD_BITS (COORD_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pix_if.sink),
        .result(res_if.source),
        .cfg   (cfg_if.sink)
    );

    blend_scoreboard sb = new();

    int   cycles;
    int   burst_left;
    int   table_writes;
    int   transfers_in;
    int   settings_applied;
    bit   sender_idles;
    bit   lut_loaded[3][TABLE_DEPTH];
    pix_t loaded_list[3][$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d pixels pending", cycles, sb.pending.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: stretches of full rate, random stalls and long stall runs.
    initial
    begin
        int   run_left;
        logic run_level;
        int   rx_cycle;
        int   mode;
        res_if.ready = 1'b0;
        run_left     = 0;
        run_level    = 1'b1;
        rx_cycle     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                sb.check_result({res_if.out_red, res_if.out_green, res_if.out_blue});
            rx_cycle++;
            mode = (rx_cycle / 300) % 3;
            if (run_left == 0)
            begin
                run_level = ~run_level;
                run_left  = run_level ? $urandom_range(1, 10) : $urandom_range(1, 14);
            end
            run_left--;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 9) < 6);
                default: res_if.ready <= run_level;
            endcase
        end
    end

    function automatic pixel_item_t table_item(logic [1:0] ch, pix_t idx, pix_t val);
        pixel_item_t it;
        it.command       = CMD_TABLE_WRITE;
        it.table_channel = ch;
        it.table_index   = idx;
        it.table_value   = val;
        it.dest_x        = coord_t'($urandom);
        it.dest_y        = coord_t'($urandom);
        it.src_red       = pix_t'($urandom);
        it.src_green     = pix_t'($urandom);
        it.src_blue      = pix_t'($urandom);
        it.src_alpha     = pix_t'($urandom);
        return it;
    endfunction

    function automatic pixel_item_t pixel_item(coord_t x, coord_t y,
                                               pix_t r, pix_t g, pix_t b, pix_t a);
        pixel_item_t it;
        it.command       = CMD_RENDER;
        it.table_channel = 2'($urandom);
        it.table_index   = pix_t'($urandom);
        it.table_value   = pix_t'($urandom);
        it.dest_x        = x;
        it.dest_y        = y;
        it.src_red       = r;
        it.src_green     = g;
        it.src_blue      = b;
        it.src_alpha     = a;
        return it;
    endfunction

    // Source samples only index table entries that have been loaded.
    function automatic pixel_item_t random_pixel();
        int   pick;
        int   ri;
        int   gi;
        int   bi;
        pix_t a;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       a = ALPHA_CLEAR;
            1:       a = ALPHA_OPAQUE;
            2:       a = pix_t'(1);
            3:       a = pix_t'(254);
            default: a = pix_t'($urandom);
        endcase
        ri = $urandom_range(0, loaded_list[CH_RED].size() - 1);
        gi = $urandom_range(0, loaded_list[CH_GREEN].size() - 1);
        bi = $urandom_range(0, loaded_list[CH_BLUE].size() - 1);
        return pixel_item(coord_t'($urandom), coord_t'($urandom),
                          loaded_list[CH_RED][ri], loaded_list[CH_GREEN][gi],
                          loaded_list[CH_BLUE][bi], a);
    endfunction

    function automatic pixel_item_t random_table_write();
        logic [1:0] ch;
        pix_t       val;
        ch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(CH_RED, CH_BLUE));
        case ($urandom_range(0, 7))
            0:       val = 8'h00;
            1:       val = 8'hFF;
            default: val = pix_t'($urandom);
        endcase
        return table_item(ch, pix_t'($urandom), val);
    endfunction

    task automatic send_item(input pixel_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = (!sender_idles || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        pix_if.valid         <= 1'b1;
        pix_if.command       <= it.command;
        pix_if.table_channel <= it.table_channel;
        pix_if.table_index   <= it.table_index;
        pix_if.table_value   <= it.table_value;
        pix_if.dest_x        <= it.dest_x;
        pix_if.dest_y        <= it.dest_y;
        pix_if.src_red       <= it.src_red;
        pix_if.src_green     <= it.src_green;
        pix_if.src_blue      <= it.src_blue;
        pix_if.src_alpha     <= it.src_alpha;
        do @(posedge clk); while (!pix_if.ready);
        sb.note_input(it);
        transfers_in++;
        burst_left--;
        if (it.command == CMD_TABLE_WRITE)
        begin
            table_writes++;
            if (it.table_channel <= CH_BLUE && !lut_loaded[it.table_channel][it.table_index])
            begin
                lut_loaded[it.table_channel][it.table_index] = 1'b1;
                loaded_list[it.table_channel].push_back(it.table_index);
            end
        end
    endtask

    // Waits at least one cycle, then until every pixel has come out, then settles if asked.
    task automatic drain(input bit settle);
        pix_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending.size() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Narrow registers get random upper data bits, which the block must ignore.
    task automatic apply_settings(input bit mode_only, input logic am, input ofs_t xo,
                                  input ofs_t yo, input pix_t dk, input pix_t lt);
        reg_write_t regs[5];
        int         n;
        regs[0].idx  = CFG_ALPHA_MODE;
        regs[0].data = CFG_DATA_W'($urandom);
        regs[0].data[0] = am;
        regs[1].idx  = CFG_X_OFFSET;
        regs[1].data = xo;
        regs[2].idx  = CFG_Y_OFFSET;
        regs[2].data = yo;
        regs[3].idx  = CFG_DARK_LEVEL;
        regs[3].data = CFG_DATA_W'($urandom);
        regs[3].data[PIX_W-1:0] = dk;
        regs[4].idx  = CFG_LIGHT_LEVEL;
        regs[4].data = CFG_DATA_W'($urandom);
        regs[4].data[PIX_W-1:0] = lt;
        n = mode_only ? 1 : 5;
        for (int i = 0; i < n; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[i].idx;
            cfg_if.data  <= regs[i].data;
            do @(posedge clk); while (!cfg_if.ready);
            sb.set_reg(regs[i].idx, regs[i].data);
        end
        cfg_if.valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.command       = CMD_TABLE_WRITE;
        pix_if.table_channel = CH_RED;
        pix_if.table_index   = '0;
        pix_if.table_value   = '0;
        pix_if.dest_x        = '0;
        pix_if.dest_y        = '0;
        pix_if.src_red       = '0;
        pix_if.src_green     = '0;
        pix_if.src_blue      = '0;
        pix_if.src_alpha     = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_ALPHA_MODE;
        cfg_if.data          = '0;
        burst_left           = 0;
        table_writes         = 0;
        transfers_in         = 0;
        settings_applied     = 0;
        sender_idles         = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: plain table lookup, extreme table entries, an ignored channel.
        send_item(table_item(CH_RED, 8'd0, 8'd255));
        send_item(table_item(CH_RED, 8'd255, 8'd0));
        send_item(table_item(CH_GREEN, 8'd0, 8'h80));
        send_item(table_item(CH_GREEN, 8'd255, 8'd255));
        send_item(table_item(CH_BLUE, 8'd0, 8'd0));
        send_item(table_item(CH_BLUE, 8'd255, 8'hAA));
        send_item(table_item(2'd3, 8'd0, 8'h55));
        send_item(pixel_item(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'h80));
        send_item(pixel_item(12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'd255, ALPHA_OPAQUE));

        // Alpha on with the reset offsets and levels.
        drain(1'b1);
        apply_settings(1'b1, 1'b1, '0, '0, '0, '0);
        send_item(pixel_item(12'd0, 12'd0, 8'd0, 8'd255, 8'd0, ALPHA_CLEAR));
        send_item(pixel_item(12'd16, 12'd0, 8'd0, 8'd255, 8'd0, ALPHA_CLEAR));
        send_item(pixel_item(12'd5, 12'd16, 8'd255, 8'd0, 8'd255, ALPHA_OPAQUE));

        drain(1'b1);
        apply_settings(1'b0, 1'b1, 16'hFFFF, 16'h0010, 8'h10, 8'hF0);
        send_item(pixel_item(12'hFFF, 12'd0, 8'd255, 8'd255, 8'd255, ALPHA_CLEAR));
        send_item(pixel_item(12'd1, 12'd1, 8'd0, 8'd0, 8'd0, 8'd1));
        send_item(pixel_item(12'd17, 12'd3, 8'd255, 8'd255, 8'd255, 8'd254));
        send_item(pixel_item(12'd100, 12'd200, 8'd0, 8'd255, 8'd0, 8'd128));
        send_item(pixel_item(12'hFFF, 12'hFFF, 8'd0, 8'd255, 8'd0, ALPHA_OPAQUE));
        send_item(pixel_item(12'd31, 12'd15, 8'd255, 8'd0, 8'd255, 8'd1));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain(1'b1);
            case (phase)
                0: apply_settings(1'b0, 1'b0, ofs_t'($urandom), ofs_t'($urandom),
                                  pix_t'($urandom), pix_t'($urandom));
                1: apply_settings(1'b0, 1'b1, '0, '0, '0, '0);
                2: apply_settings(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                4: apply_settings(1'b0, 1'b1, ofs_t'($urandom), ofs_t'($urandom),
                                  8'hFF, 8'h00);
                default: apply_settings(1'b0, 1'b1, ofs_t'($urandom), ofs_t'($urandom),
                                        pix_t'($urandom), pix_t'($urandom));
            endcase
            sender_idles = (phase != 4);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (phase == 3 && n == 150)
                    drain(1'b0);
                if ($urandom_range(0, 99) < ((phase == 0) ? 50 : 25))
                    send_item(random_table_write());
                else
                    send_item(random_pixel());
            end
        end

        drain(1'b1);
        $display("Sent %0d transfers, %0d of them color table writes, under %0d register settings.",
                 transfers_in, table_writes, settings_applied);
        $display("Checked %0d rendered pixels in lookup, checker, raw and blend cases.",
                 sb.checked);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
